/* sv/dqab_pkg.sv */
// Shared sizes and types of the DNS answer builder.
package dqab_pkg;

   localparam int BUFFER_BYTES = 512;
   localparam int ADDR_W       = $clog2(BUFFER_BYTES);
   localparam int COUNT_W      = $clog2(BUFFER_BYTES + 1);
   // Widest walk position: last byte, a 255-byte label plus its length, then 5 more
   localparam int POS_W        = $clog2(BUFFER_BYTES + 262);

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } store_wr_type;

endpackage

/* sv/dqab_store.sv */
// Packet byte store: one write port, one read port with registered data.
module dqab_store import dqab_pkg::*; (
   input  logic              clock,
   input  store_wr_type      wr,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] store_ff [BUFFER_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/dns_query_answer_builder.sv */
// Top level of the DNS answer builder: receive, question walk and response packing.
// Input: one byte per cycle while busy is low; a last byte ending a 12+ byte packet raises busy.
// After the last byte: fetch of the question count, a walk of each label including the
// zero label that ends a name, a fit check, then one byte per cycle; the receiver cannot stall,
// busy drops as the last word goes out. Reset (sync): idle, byte count 0, address 0; store kept.
module dns_query_answer_builder import dqab_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   output logic        rsp_strobe,
   output logic [63:0] rsp_out_data,
   output logic [3:0]  rsp_out_count,
   output logic        rsp_out_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_answer_address
);

   // sequencer states
   localparam logic [2:0] ST_RECV    = 3'd0;
   localparam logic [2:0] ST_QD_ADDR = 3'd1;
   localparam logic [2:0] ST_QD_HI   = 3'd2;
   localparam logic [2:0] ST_QD_LO   = 3'd3;
   localparam logic [2:0] ST_WALK    = 3'd4;
   localparam logic [2:0] ST_LABEL   = 3'd5;
   localparam logic [2:0] ST_FIT     = 3'd6;
   localparam logic [2:0] ST_EMIT    = 3'd7;

   localparam int HEADER_BYTES = 12;
   localparam int ANSWER_BYTES = 16;
   localparam int QUESTION_TAIL = 5;   // zero label, type, class

   localparam logic [ADDR_W-1:0] QDCOUNT_HI_ADDR = ADDR_W'(4);
   localparam logic [ADDR_W-1:0] QDCOUNT_LO_ADDR = ADDR_W'(5);

   localparam logic [7:0] FLAGS_HI   = 8'h81;
   localparam logic [7:0] FLAGS_LO   = 8'h80;
   localparam logic [7:0] NAME_PTR_HI = 8'hC0;
   localparam logic [7:0] NAME_PTR_LO = 8'h0C;
   localparam logic [7:0] TTL_LO     = 8'h3C;
   localparam logic [7:0] RDLEN_LO   = 8'h04;

   // header bytes rewritten in the response; everything else is copied
   function automatic logic [7:0] query_byte(logic [POS_W-1:0] idx, logic [7:0] data);
      logic [7:0] b;
      b = data;
      case (idx)
         POS_W'(2):  b = FLAGS_HI;
         POS_W'(3):  b = FLAGS_LO;
         POS_W'(7):  b = 8'h01;        // answer count 1
         POS_W'(6), POS_W'(8), POS_W'(9), POS_W'(10), POS_W'(11): b = 8'h00;
         default:    b = data;
      endcase
      return b;
   endfunction

   // fixed A record: name pointer, type A, class IN, TTL 60, length 4, address
   function automatic logic [7:0] answer_byte(logic [3:0] idx, logic [31:0] addr);
      logic [7:0] b;
      case (idx)
         4'd0:    b = NAME_PTR_HI;
         4'd1:    b = NAME_PTR_LO;
         4'd3:    b = 8'h01;
         4'd5:    b = 8'h01;
         4'd9:    b = TTL_LO;
         4'd11:   b = RDLEN_LO;
         4'd12:   b = addr[31:24];
         4'd13:   b = addr[23:16];
         4'd14:   b = addr[15:8];
         4'd15:   b = addr[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   logic [2:0]         state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [POS_W-1:0]   len_ff, len_in;
   logic [7:0]         qd_hi_ff, qd_hi_in;
   logic [15:0]        qd_ff, qd_in;
   logic [15:0]        q_ff, q_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   total_ff, total_in;
   logic [POS_W-1:0]   issue_ff, issue_in;
   logic               p_vld_ff, p_vld_in;
   logic [POS_W-1:0]   p_idx_ff, p_idx_in;
   logic [63:0]        word_ff, word_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [63:0]        rsp_data_ff, rsp_data_in;
   logic [3:0]         rsp_count_ff, rsp_count_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [31:0]        answer_addr_ff;

   store_wr_type      store_wr;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;

   logic             accepted;
   logic             room;
   logic [POS_W-1:0] name_end;
   logic [POS_W-1:0] label_next;
   logic [15:0]      qd_read;
   logic [7:0]       out_byte;
   logic [2:0]       lane;
   logic [63:0]      merged;
   logic             is_last;

   dqab_store u_store (
      .clock   (clock),
      .wr      (store_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy      = (state_ff != ST_RECV);
   assign accepted  = start && !busy;
   assign room      = (count_ff < COUNT_W'(BUFFER_BYTES));
   assign csr_ready = 1'b1;

   // bytes past the buffer are dropped, count saturates
   assign store_wr.en   = accepted && room;
   assign store_wr.addr = count_ff[ADDR_W-1:0];
   assign store_wr.data = req_in_byte;

   assign name_end   = pos_ff + POS_W'(QUESTION_TAIL);
   assign label_next = pos_ff + POS_W'(rd_data) + POS_W'(1);
   assign qd_read    = {qd_hi_ff, rd_data};

   // response byte arriving from the read issued last cycle
   assign out_byte = (p_idx_ff < pos_ff) ? query_byte(p_idx_ff, rd_data)
                                         : answer_byte(4'(p_idx_ff - pos_ff), answer_addr_ff);
   assign lane     = p_idx_ff[2:0];
   assign merged   = word_ff | ({out_byte, 56'd0} >> {lane, 3'b000});
   assign is_last  = (p_idx_ff == total_ff - POS_W'(1));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      len_in        = len_ff;
      qd_hi_in      = qd_hi_ff;
      qd_in         = qd_ff;
      q_in          = q_ff;
      pos_in        = pos_ff;
      total_in      = total_ff;
      issue_in      = issue_ff;
      p_vld_in      = 1'b0;
      p_idx_in      = p_idx_ff;
      word_in       = word_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      rd_addr       = '0;

      case (state_ff)
         ST_RECV: begin
            if (accepted) begin
               if (room) begin
                  count_in = count_ff + COUNT_W'(1);
               end
               if (req_in_last) begin
                  len_in   = POS_W'(count_ff) + (room ? POS_W'(1) : POS_W'(0));
                  count_in = '0;
                  // runt packets drop right here
                  if (len_in >= POS_W'(HEADER_BYTES)) begin
                     state_in = ST_QD_ADDR;
                  end
               end
            end
         end
         ST_QD_ADDR: begin
            rd_addr  = QDCOUNT_HI_ADDR;
            state_in = ST_QD_HI;
         end
         ST_QD_HI: begin
            rd_addr  = QDCOUNT_LO_ADDR;
            qd_hi_in = rd_data;
            state_in = ST_QD_LO;
         end
         ST_QD_LO: begin
            if (qd_read == 16'd0) begin
               state_in = ST_RECV;
            end else begin
               qd_in    = qd_read;
               q_in     = '0;
               pos_in   = POS_W'(HEADER_BYTES);
               state_in = ST_WALK;
            end
         end
         ST_WALK, ST_LABEL: begin
            if (state_ff == ST_WALK && pos_ff < len_ff) begin
               rd_addr  = pos_ff[ADDR_W-1:0];
               state_in = ST_LABEL;
            end else if (state_ff == ST_LABEL && rd_data != 8'd0) begin
               pos_in   = label_next;
               state_in = ST_WALK;
            end else begin
               // end of one name; overrun clamps to the packet length
               if (name_end > len_ff) begin
                  pos_in   = len_ff;
                  state_in = ST_FIT;
               end else begin
                  pos_in   = name_end;
                  q_in     = q_ff + 16'd1;
                  state_in = (q_ff + 16'd1 == qd_ff) ? ST_FIT : ST_WALK;
               end
            end
         end
         ST_FIT: begin
            if (pos_ff + POS_W'(ANSWER_BYTES) > POS_W'(BUFFER_BYTES)) begin
               state_in = ST_RECV;
            end else begin
               total_in = pos_ff + POS_W'(ANSWER_BYTES);
               issue_in = '0;
               word_in  = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // issue side: one read per cycle
            rd_addr  = issue_ff[ADDR_W-1:0];
            p_idx_in = issue_ff;
            if (issue_ff < total_ff) begin
               issue_in = issue_ff + POS_W'(1);
               p_vld_in = 1'b1;
            end
            // pack side: fill lanes from the top, flush on lane 7 or the last byte
            if (p_vld_ff) begin
               if (lane == 3'd7 || is_last) begin
                  rsp_strobe_in = 1'b1;
                  rsp_data_in   = merged;
                  rsp_count_in  = {1'b0, lane} + 4'd1;
                  rsp_last_in   = is_last;
                  word_in       = '0;
                  if (is_last) begin
                     state_in = ST_RECV;
                  end
               end else begin
                  word_in = merged;
               end
            end
         end
         default: begin
            state_in = ST_RECV;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_RECV;
         count_ff       <= '0;
         p_vld_ff       <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
         answer_addr_ff <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         p_vld_ff      <= p_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            answer_addr_ff <= csr_answer_address;
         end
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      len_ff       <= len_in;
      qd_hi_ff     <= qd_hi_in;
      qd_ff        <= qd_in;
      q_ff         <= q_in;
      pos_ff       <= pos_in;
      total_ff     <= total_in;
      issue_ff     <= issue_in;
      p_idx_ff     <= p_idx_in;
      word_ff      <= word_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_out_data  = rsp_data_ff;
   assign rsp_out_count = rsp_count_ff;
   assign rsp_out_last  = rsp_last_ff;

`ifndef SYNTH
   a_mid_word_full: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_out_last |-> rsp_out_count == 4'd8)
      else $error("non-final word not full");

   a_mid_word_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_out_last |-> busy)
      else $error("response word after sequencer went idle");

   a_idle_no_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RECV |-> !p_vld_ff)
      else $error("pending store read while receiving");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> issue_ff <= total_ff)
      else $error("read issue ran past response length");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(BUFFER_BYTES))
      else $error("byte count past buffer size");
`endif

endmodule

/* test/tb_dns_query_answer_builder.sv */
// Self-checking testbench of the DNS answer builder: directed and random queries.
module tb_dns_query_answer_builder;
   import dqab_pkg::*;

   // Wire-format constants of the answer, as the block builds it
   localparam int          HEADER_BYTES  = 12;
   localparam int          ANSWER_BYTES  = 16;
   localparam logic [15:0] RESP_FLAGS    = 16'h8180;  // response, recursion desired/available
   localparam logic [15:0] ANCOUNT_ONE   = 16'h0001;
   localparam logic [15:0] NAME_PTR      = 16'hC00C;  // compressed pointer to the first name
   localparam logic [15:0] RR_TYPE_A     = 16'h0001;
   localparam logic [15:0] RR_CLASS_IN   = 16'h0001;
   localparam logic [31:0] TTL_SECONDS   = 32'h0000003C;
   localparam logic [15:0] RDATA_LEN     = 16'h0004;

   // Worst case after the last byte in: full-store name walk plus 64 output words
   localparam int LATENCY_GUARD = 1200;
   localparam int CYCLE_LIMIT   = 60000;

   typedef enum logic [1:0] {FILL_RAND, FILL_ZERO, FILL_ONES} fill_type;

   // One directed query: length (0 = natural), question count, names to lay down,
   // label length range, filler, and a typed word count (-1 = ask the predictor).
   typedef struct packed {
      int       len;
      int       qd;
      int       names;
      int       lbl_lo;
      int       lbl_hi;
      fill_type fill;
      int       typed;
   } probe_type;

   typedef struct packed {
      logic [63:0] data;
      logic [3:0]  count;
      logic        last;
   } reply_word_type;

   localparam int PROBE_COUNT = 10;
   localparam probe_type PROBES [PROBE_COUNT] = '{
      // typed rows below are drops: no response word may appear
      '{1,     1,     0, 0,   0,   FILL_RAND, 0},   // one-byte runt right after reset
      '{11,    1,     0, 0,   0,   FILL_ONES, 0},   // runt, one short of a header
      '{12,    0,     0, 0,   0,   FILL_ONES, 0},   // no questions
      '{12,    1,     0, 0,   0,   FILL_ONES, -1},  // bare header, walk runs off the end
      '{0,     1,     1, 1,   8,   FILL_RAND, -1},  // one ordinary question
      '{0,     2,     2, 1,   4,   FILL_RAND, -1},  // two questions
      '{0,     65535, 1, 1,   8,   FILL_RAND, -1},  // count claims more than present
      '{24,    1,     1, 255, 255, FILL_ONES, -1},  // label length points past the end
      '{0,     3,     3, 0,   0,   FILL_RAND, -1},  // root names only
      '{20,    1,     0, 0,   0,   FILL_ZERO, -1}   // zero id, zero body
   };

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [7:0]  req_in_byte;
   logic        req_in_last;
   logic        rsp_strobe;
   logic [63:0] rsp_out_data;
   logic [3:0]  rsp_out_count;
   logic        rsp_out_last;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_answer_address;

   // Shadow of the block: kept query bytes, their count and the answer address
   logic [7:0]  query_mem [BUFFER_BYTES];
   int          query_len;
   logic [31:0] a_record_ip;
   logic [7:0]  reply_mem [BUFFER_BYTES];

   reply_word_type reply_q [$];   // response words still owed by the block
   logic [7:0]  query_bytes [$];  // query being sent
   int          fed_bytes;        // bytes kept by the block
   int          words_owed;       // response words predicted so far
   int          fault_count;
   int          cycles;

   dns_query_answer_builder u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_in_byte        (req_in_byte),
      .req_in_last        (req_in_last),
      .rsp_strobe         (rsp_strobe),
      .rsp_out_data       (rsp_out_data),
      .rsp_out_count      (rsp_out_count),
      .rsp_out_last       (rsp_out_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_answer_address (csr_answer_address)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Response length for the kept query, built in reply_mem; 0 means dropped.
   function automatic int build_reply(int len);
      int qd, q, pos, i;
      logic [127:0] a_rec;
      if (len < HEADER_BYTES) return 0;
      qd = {query_mem[4], query_mem[5]};
      if (qd == 0) return 0;
      // Skip each question name label by label, then type and class
      pos = HEADER_BYTES;
      for (q = 0; q < qd; q++) begin
         while (pos < len && query_mem[pos] != 8'h00) pos += query_mem[pos] + 1;
         pos += 5;
         if (pos > len) begin
            pos = len;
            break;
         end
      end
      if (pos + ANSWER_BYTES > BUFFER_BYTES) return 0;
      for (i = 0; i < pos; i++) reply_mem[i] = query_mem[i];
      {reply_mem[2], reply_mem[3]} = RESP_FLAGS;
      {reply_mem[6], reply_mem[7]} = ANCOUNT_ONE;
      for (i = 8; i < HEADER_BYTES; i++) reply_mem[i] = 8'h00;
      a_rec = {NAME_PTR, RR_TYPE_A, RR_CLASS_IN, TTL_SECONDS, RDATA_LEN, a_record_ip};
      for (i = 0; i < ANSWER_BYTES; i++) reply_mem[pos + i] = a_rec[127 - 8 * i -: 8];
      return pos + ANSWER_BYTES;
   endfunction

   // Track one accepted byte; on the last one queue the response words.
   // With post low the state moves on but the expectation comes from the table.
   task automatic absorb_byte(input logic [7:0] b, input logic last, input bit post);
      int rlen, base, n, k;
      reply_word_type w;
      if (query_len < BUFFER_BYTES) begin
         query_mem[query_len] = b;
         query_len++;
         fed_bytes++;
      end
      if (!last) return;
      rlen = build_reply(query_len);
      query_len = 0;
      if (!post) return;
      for (base = 0; base < rlen; base += 8) begin
         n = (rlen - base > 8) ? 8 : rlen - base;
         w.data = '0;
         for (k = 0; k < n; k++) w.data[63 - 8 * k -: 8] = reply_mem[base + k];
         w.count = n[3:0];
         w.last = (base + n >= rlen);
         reply_q.push_back(w);
         words_owed++;
      end
   endtask

   function automatic logic [7:0] fill_byte(fill_type fill);
      case (fill)
         FILL_ZERO: return 8'h00;
         FILL_ONES: return 8'hFF;
         default:   return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic compose_query(input int len, input int qd, input int names,
                                input int lbl_lo, input int lbl_hi, input fill_type fill);
      int n, l, c, nlab, ll;
      logic [15:0] qd16;
      qd16 = qd[15:0];
      query_bytes.delete();
      for (c = 0; c < HEADER_BYTES; c++) query_bytes.push_back(fill_byte(fill));
      query_bytes[4] = qd16[15:8];
      query_bytes[5] = qd16[7:0];
      for (n = 0; n < names; n++) begin
         nlab = (lbl_hi > 0) ? $urandom_range(1, 3) : 0;
         for (l = 0; l < nlab; l++) begin
            ll = $urandom_range(lbl_lo, lbl_hi);
            query_bytes.push_back(ll[7:0]);
            for (c = 0; c < ll; c++) query_bytes.push_back(fill_byte(FILL_RAND));
         end
         query_bytes.push_back(8'h00);
         // qtype and qclass
         for (c = 0; c < 4; c++) query_bytes.push_back(fill_byte(FILL_RAND));
      end
      if (len > 0) begin
         while (query_bytes.size() > len) void'(query_bytes.pop_back());
         while (query_bytes.size() < len) query_bytes.push_back(fill_byte(fill));
      end
   endtask

   // Mostly well-formed queries with random names; the rest truncated, lying
   // about the question count, runts, empty, noise, or all-zero bodies.
   task automatic random_query();
      int sel, qd, cut;
      sel = $urandom_range(0, 99);
      qd = $urandom_range(1, 3);
      if (sel < 60) begin
         compose_query(0, qd, qd, 1, 8, FILL_RAND);
         repeat ($urandom_range(0, 3)) query_bytes.push_back(fill_byte(FILL_RAND));
      end else if (sel < 72) begin
         compose_query(0, qd, qd, 1, 12, FILL_RAND);
         cut = $urandom_range(HEADER_BYTES, query_bytes.size());
         while (query_bytes.size() > cut) void'(query_bytes.pop_back());
      end else if (sel < 80) begin
         compose_query(0, $urandom_range(qd + 1, 65535), qd, 1, 8, FILL_RAND);
      end else if (sel < 86) begin
         compose_query($urandom_range(1, HEADER_BYTES - 1), qd, 0, 0, 0, FILL_RAND);
      end else if (sel < 91) begin
         compose_query($urandom_range(HEADER_BYTES, 24), 0, 1, 1, 6, FILL_RAND);
      end else if (sel < 97) begin
         compose_query($urandom_range(HEADER_BYTES, 32), $urandom_range(0, 65535),
                       0, 0, 0, FILL_RAND);
      end else begin
         compose_query($urandom_range(HEADER_BYTES, 32), 65535, 0, 0, 0, FILL_ZERO);
      end
   endtask

   // Called at a falling edge; returns at the falling edge after the byte is taken.
   // rate: 0 no idling, 1 sparse bursts, 2 dense bursts.
   task automatic feed_byte(input logic [7:0] b, input logic last, input bit post,
                            input int rate);
      bit idle;
      idle = (rate == 1) ? ($urandom_range(0, 9) == 0) :
             (rate == 2) ? ($urandom_range(0, 2) == 0) : 1'b0;
      if (idle) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      start <= 1'b1;
      req_in_byte <= b;
      req_in_last <= last;
      // busy read here is its value before this edge
      do @(posedge clock); while (busy);
      absorb_byte(b, last, post);
      @(negedge clock);
   endtask

   task automatic feed_query(input bit post, input bit idle_ok);
      int i, rate;
      rate = idle_ok ? $urandom_range(0, 2) : 0;
      for (i = 0; i < query_bytes.size(); i++)
         feed_byte(query_bytes[i], i == query_bytes.size() - 1, post, rate);
   endtask

   // Sender holds off until every owed word is out, then lets a dropped
   // query finish its walk before anything else happens.
   task automatic settle();
      start <= 1'b0;
      while (reply_q.size() != 0) @(posedge clock);
      repeat (LATENCY_GUARD) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic program_address(input logic [31:0] ip);
      csr_valid <= 1'b1;
      csr_answer_address <= ip;
      do @(posedge clock); while (!csr_ready);
      a_record_ip = ip;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(input int min_bytes, input int min_words, input bit idle_ok);
      int b0, w0;
      b0 = fed_bytes;
      w0 = words_owed;
      while (fed_bytes - b0 < min_bytes || words_owed - w0 < min_words) begin
         random_query();
         feed_query(1'b1, idle_ok);
      end
   endtask

   task automatic run_probe(input int r);
      compose_query(PROBES[r].len, PROBES[r].qd, PROBES[r].names,
                    PROBES[r].lbl_lo, PROBES[r].lbl_hi, PROBES[r].fill);
      feed_query(PROBES[r].typed < 0, 1'b1);
   endtask

   task automatic note_fault(input string what, input logic [63:0] want,
                             input logic [63:0] got);
      fault_count++;
      if (fault_count <= 10)
         $display("mismatch on %s: expected %h, got %h", what, want, got);
   endtask

   // Response side: every strobed word is taken at the edge that ends its cycle
   always @(posedge clock) begin
      reply_word_type want;
      if (!reset && rsp_strobe) begin
         if (reply_q.size() == 0) begin
            note_fault("unexpected word", 64'h0, rsp_out_data);
         end else begin
            want = reply_q.pop_front();
            if (rsp_out_data !== want.data) note_fault("data", want.data, rsp_out_data);
            if (rsp_out_count !== want.count)
               note_fault("count", 64'(want.count), 64'(rsp_out_count));
            if (rsp_out_last !== want.last)
               note_fault("last", 64'(want.last), 64'(rsp_out_last));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_dns_query_answer_builder: errors");
         $finish;
      end
   end

   initial begin
      int r;
      reset = 1'b1;
      start = 1'b0;
      req_in_byte = 8'h00;
      req_in_last = 1'b0;
      csr_valid = 1'b0;
      csr_answer_address = 32'h0;
      query_len = 0;
      a_record_ip = 32'h0;
      fed_bytes = 0;
      words_owed = 0;
      fault_count = 0;
      cycles = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, first half with the address still at its reset value
      for (r = 0; r < 5; r++) run_probe(r);
      settle();
      program_address(32'hFFFF_FFFF);
      for (r = 5; r < PROBE_COUNT; r++) run_probe(r);

      // Random part, then a closing stretch with the sender never idling
      settle();
      program_address($urandom);
      random_phase(30, 2, 1'b1);
      settle();
      program_address(32'h0000_0000);
      random_phase(20, 1, 1'b1);
      random_phase(20, 1, 1'b0);

      settle();
      if (reply_q.size() != 0) note_fault("words still owed", 64'h0, 64'(reply_q.size()));
      if (fault_count == 0) begin
         $display("tb_dns_query_answer_builder: clean");
      end else begin
         $display("tb_dns_query_answer_builder: errors");
      end
      $finish;
   end

endmodule
